>>> rtl/qpt_pkg.sv
// ----------------------------------------------------------------------------
// qpt_pkg
// Types and constants shared by the quaternion pose point transform.
// ----------------------------------------------------------------------------
package qpt_pkg;

  localparam int COORD_W = 48;
  localparam int QUAT_W  = 32;
  localparam int FRAC_Q  = 30;
  localparam int ROT_W   = 37;
  localparam int CFG_IDX_W = 3;
  localparam int SPLIT   = 24;
  localparam int LO_W    = ROT_W + SPLIT + 1;
  localparam int HI_W    = ROT_W + COORD_W - SPLIT;
  localparam int TERM_W  = ROT_W + COORD_W;
  localparam int ACC_W   = TERM_W + 3;

  localparam logic [QUAT_W-1:0] QUAT_W_RESET = 32'h4000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [ROT_W-1:0]   rot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_QUAT_W   = 3'd0,
    IDX_QUAT_X   = 3'd1,
    IDX_QUAT_Y   = 3'd2,
    IDX_QUAT_Z   = 3'd3,
    IDX_SHIFT_X  = 3'd4,
    IDX_SHIFT_Y  = 3'd5,
    IDX_SHIFT_Z  = 3'd6,
    IDX_POSE_EN  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                 ready;
    rot_t   [2:0][2:0]    rot;
    coord_t [2:0]         shift;
  } pose_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   overflow;
  } result_t;

endpackage

>>> rtl/qpt_point_if.sv
// ----------------------------------------------------------------------------
// qpt_point_if
// Input point channel: valid/ready handshake with three Q32.16 coordinates.
// ----------------------------------------------------------------------------
interface qpt_point_if import qpt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

>>> rtl/qpt_result_if.sv
// ----------------------------------------------------------------------------
// qpt_result_if
// Result channel: valid/ready handshake with transformed point and flag.
// ----------------------------------------------------------------------------
interface qpt_result_if import qpt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   overflow;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output overflow, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input overflow, output ready);
endinterface

>>> rtl/quaternion_pose_point_transform_core.sv
// ----------------------------------------------------------------------------
// quaternion_pose_point_transform_core
// Applies a quaternion pose and translation to a stream of 3-D points.
// ----------------------------------------------------------------------------
// Usage:
//   point_i carries one Q32.16 point per beat; result_o returns R*p+t per
//   beat, saturated to 48 bits, with overflow set when any axis clamped.
//   With the pose enable (IDX_POSE_EN) clear every point passes through unchanged.
//   The pose is loaded through cfg_we_i/cfg_idx_i/cfg_data_i while the
//   stream is idle; the matrix is rebuilt in two register stages, so
//   point_i.ready stays low after any write until both have reloaded.
//   Throughput: one point per cycle while result_o is ready and the pose
//   has settled, set by the five-stage point pipeline (input, split 37x25
//   and 37x24 products, term merge, row sum, round/saturate).
//   A stalled result_o holds its beat; upstream stages keep filling any
//   bubbles, so ready drops only when every stage is occupied or while the
//   pose settles. Reset: pose registers return to the identity quaternion,
//   zero shift and no pose; the pipeline empties and ready rises once settled.
// ----------------------------------------------------------------------------
module quaternion_pose_point_transform_core import qpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  qpt_point_if.sink            point_i,
  qpt_result_if.source         result_o
);

  pose_t        pose;
  coord_t [2:0] in_pt;
  result_t      res;

  assign in_pt[0] = point_i.point_x;
  assign in_pt[1] = point_i.point_y;
  assign in_pt[2] = point_i.point_z;

  qpt_rot_gen u_rot_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pose_o     (pose)
  );

  qpt_xform_pipe u_xform_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pose_i      (pose),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (point_i.ready),
    .in_pt_i     (in_pt),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_res_o   (res)
  );

  assign result_o.out_x    = res.out_x;
  assign result_o.out_y    = res.out_y;
  assign result_o.out_z    = res.out_z;
  assign result_o.overflow = res.overflow;

endmodule

>>> rtl/qpt_rot_gen.sv
// ----------------------------------------------------------------------------
// qpt_rot_gen
// Pose registers and two-stage rotation matrix build from the quaternion.
// ----------------------------------------------------------------------------
module qpt_rot_gen import qpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  output pose_t                pose_o
);

  localparam logic [1:0] SETTLE_CYC = 2'd2;
  localparam rot_t ONE = rot_t'(64'sd1 <<< FRAC_Q);

  quat_t        qw_q, qx_q, qy_q, qz_q;
  coord_t [2:0] shift_q;
  logic         pose_en_q;
  logic [1:0]   settle_q, settle_d;

  logic signed [2*QUAT_W-1:0] xx_q, yy_q, zz_q, wz_q, xz_q, yz_q, wy_q, xy_q, wx_q;
  rot_t xx, yy, zz, wz, xz, yz, wy, xy, wx;
  rot_t   [2:0][2:0] rot_d, rot_q;
  coord_t [2:0]      shd_d, shd_q;

  function automatic rot_t rnd_q30(input logic signed [2*QUAT_W-1:0] p);
    logic [2*QUAT_W-1:0] s;
    s = p + ((2*QUAT_W)'(1) << (FRAC_Q - 1));
    return rot_t'($signed(s[2*QUAT_W-1:FRAC_Q]));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q      <= QUAT_W_RESET;
      qx_q      <= '0;
      qy_q      <= '0;
      qz_q      <= '0;
      shift_q   <= '0;
      pose_en_q <= 1'b0;
      settle_q  <= SETTLE_CYC;
    end else begin
      settle_q <= settle_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          IDX_QUAT_W:  qw_q       <= cfg_data_i[QUAT_W-1:0];
          IDX_QUAT_X:  qx_q       <= cfg_data_i[QUAT_W-1:0];
          IDX_QUAT_Y:  qy_q       <= cfg_data_i[QUAT_W-1:0];
          IDX_QUAT_Z:  qz_q       <= cfg_data_i[QUAT_W-1:0];
          IDX_SHIFT_X: shift_q[0] <= cfg_data_i;
          IDX_SHIFT_Y: shift_q[1] <= cfg_data_i;
          IDX_SHIFT_Z: shift_q[2] <= cfg_data_i;
          IDX_POSE_EN: pose_en_q  <= cfg_data_i[0];
        endcase
      end
    end
  end

  // hold the point path off until the matrix has caught up with a write
  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = SETTLE_CYC;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q  <= qx_q * qx_q;
    yy_q  <= qy_q * qy_q;
    zz_q  <= qz_q * qz_q;
    wz_q  <= qw_q * qz_q;
    xz_q  <= qx_q * qz_q;
    yz_q  <= qy_q * qz_q;
    wy_q  <= qw_q * qy_q;
    xy_q  <= qx_q * qy_q;
    wx_q  <= qw_q * qx_q;
    rot_q <= rot_d;
    shd_q <= shd_d;
  end

  always_comb begin
    xx = rnd_q30(xx_q);
    yy = rnd_q30(yy_q);
    zz = rnd_q30(zz_q);
    wz = rnd_q30(wz_q);
    xz = rnd_q30(xz_q);
    yz = rnd_q30(yz_q);
    wy = rnd_q30(wy_q);
    xy = rnd_q30(xy_q);
    wx = rnd_q30(wx_q);
    if (pose_en_q) begin
      rot_d[0][0] = ONE - ((yy + zz) <<< 1);
      rot_d[1][1] = ONE - ((xx + zz) <<< 1);
      rot_d[2][2] = ONE - ((xx + yy) <<< 1);
      rot_d[0][1] = (xy - wz) <<< 1;
      rot_d[1][0] = (xy + wz) <<< 1;
      rot_d[0][2] = (xz + wy) <<< 1;
      rot_d[2][0] = (xz - wy) <<< 1;
      rot_d[1][2] = (yz - wx) <<< 1;
      rot_d[2][1] = (yz + wx) <<< 1;
      shd_d       = shift_q;
    end else begin
      // identity pose passes the point through exactly
      rot_d       = '0;
      rot_d[0][0] = ONE;
      rot_d[1][1] = ONE;
      rot_d[2][2] = ONE;
      shd_d       = '0;
    end
  end

  assign pose_o.ready = (settle_q == 2'd0);
  assign pose_o.rot   = rot_q;
  assign pose_o.shift = shd_q;

endmodule

>>> rtl/qpt_xform_pipe.sv
// ----------------------------------------------------------------------------
// qpt_xform_pipe
// Five-stage point pipeline: input, split products, term merge, row sum,
// round and saturate into the output register.
// ----------------------------------------------------------------------------
module qpt_xform_pipe import qpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pose_t         pose_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  coord_t [2:0]  in_pt_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output result_t       out_res_o
);

  localparam int Q_W = ACC_W - FRAC_Q;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_Q - 1);
  localparam coord_t MAX_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t MIN_NEG = {1'b1, {(COORD_W-1){1'b0}}};

  logic [4:0] v_q;
  logic [4:0] en;

  coord_t [2:0] pt_q;
  logic signed [LO_W-1:0] lo_q   [3][3];
  logic signed [LO_W-1:0] lo_d   [3][3];
  logic signed [HI_W-1:0] hi_q   [3][3];
  logic signed [HI_W-1:0] hi_d   [3][3];
  logic [TERM_W-1:0]      term_q [3][3];
  logic [TERM_W-1:0]      term_d [3][3];
  logic [ACC_W-1:0]       acc_q  [3];
  logic [ACC_W-1:0]       acc_d  [3];
  coord_t [2:0]           res_d;
  logic   [2:0]           sat_d;
  result_t                res_q;
  logic [Q_W-1:0]         qv;
  logic [Q_W-COORD_W:0]   top;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[4] = !v_q[4] || out_ready_i;
    en[3] = !v_q[3] || en[4];
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0] && pose_i.ready;
  assign out_valid_o = v_q[4];
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i && in_ready_o;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lo_d[i][j] = $signed(pose_i.rot[i][j]) * $signed({1'b0, pt_q[j][SPLIT-1:0]});
        hi_d[i][j] = $signed(pose_i.rot[i][j]) * $signed(pt_q[j][COORD_W-1:SPLIT]);
        term_d[i][j] = (TERM_W'(hi_q[i][j]) << SPLIT) + TERM_W'(lo_q[i][j]);
      end
      acc_d[i] = ACC_W'($signed(term_q[i][0])) + ACC_W'($signed(term_q[i][1]))
               + ACC_W'($signed(term_q[i][2]))
               + (ACC_W'($signed(pose_i.shift[i])) << FRAC_Q) + ROUND_BIAS;
    end
  end

  // drop the fraction, clamp to the coordinate range
  always_comb begin
    qv  = '0;
    top = '0;
    for (int i = 0; i < 3; i++) begin
      qv  = acc_q[i][ACC_W-1:FRAC_Q];
      top = qv[Q_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
        res_d[i] = qv[COORD_W-1:0];
        sat_d[i] = 1'b0;
      end else begin
        res_d[i] = qv[Q_W-1] ? MIN_NEG : MAX_POS;
        sat_d[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) pt_q <= in_pt_i;
    if (en[1]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (en[2]) term_q <= term_d;
    if (en[3]) acc_q  <= acc_d;
    if (en[4]) begin
      res_q.out_x    <= res_d[0];
      res_q.out_y    <= res_d[1];
      res_q.out_z    <= res_d[2];
      res_q.overflow <= |sat_d;
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks every transformed point of the quaternion pose point transform
// against a bit-true predictor kept in the bench. The run starts with short
// directed phases: pass-through, identity pose with saturating shifts, a
// non-unit quaternion at its extremes, and a quarter turn. Random poses and
// points follow, with random idling on both channels, one calm phase and
// one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top import qpt_pkg::*; ();

  typedef logic signed [127:0] wide_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned POINTS_PER_PHASE = 140;
  localparam int unsigned CALM_PHASE = 5;
  localparam int unsigned HOLD_AT = 400;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned IDLE_PCT = 23;

  localparam wide_t  COORD_MAX = (wide_t'(1) <<< (COORD_W - 1)) - wide_t'(1);
  localparam wide_t  COORD_MIN = -(wide_t'(1) <<< (COORD_W - 1));
  localparam coord_t C_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
  localparam coord_t C_ONE = 48'sh1_0000;
  localparam quat_t  Q_ONE = 32'sh4000_0000;
  localparam quat_t  Q_HALF_SQRT2 = 32'sh2D41_3CCD;
  localparam quat_t  Q_MAX = 32'sh7FFF_FFFF;
  localparam quat_t  Q_MIN = 32'sh8000_0000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_W-1:0]   cfg_data_i;

  qpt_point_if  point_bus ();
  qpt_result_if result_bus ();

  quat_t       pose_quat [4];
  coord_t      pose_shift [3];
  logic        pose_on;
  logic        calm;
  point_t      point_backlog [$];
  result_t     transformed_q [$];
  point_t      next_point;
  result_t     want;
  logic        hit;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned hold_left = 0;

  always #2 clk_i = ~clk_i;

  quaternion_pose_point_transform_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .point_i    (point_bus),
    .result_o   (result_bus)
  );

  function automatic longint quat_prod(quat_t a, quat_t b);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_Q - 1));
    return p >>> FRAC_Q;
  endfunction

  function automatic result_t transform_point(point_t pt);
    longint  one, xx, yy, zz, wz, xz, yz, wy, xy, wx;
    longint  rot [3][3];
    coord_t  p [3];
    coord_t  o [3];
    wide_t   acc;
    result_t r;
    int      i, j;
    p[0] = pt.x;
    p[1] = pt.y;
    p[2] = pt.z;
    r.overflow = 1'b0;
    if (!pose_on) begin
      o = p;
    end else begin
      one = longint'(1) <<< FRAC_Q;
      xx = quat_prod(pose_quat[1], pose_quat[1]);
      yy = quat_prod(pose_quat[2], pose_quat[2]);
      zz = quat_prod(pose_quat[3], pose_quat[3]);
      wz = quat_prod(pose_quat[0], pose_quat[3]);
      xz = quat_prod(pose_quat[1], pose_quat[3]);
      yz = quat_prod(pose_quat[2], pose_quat[3]);
      wy = quat_prod(pose_quat[0], pose_quat[2]);
      xy = quat_prod(pose_quat[1], pose_quat[2]);
      wx = quat_prod(pose_quat[0], pose_quat[1]);
      rot[0][0] = one - 2 * (yy + zz);
      rot[1][1] = one - 2 * (xx + zz);
      rot[2][2] = one - 2 * (xx + yy);
      rot[0][1] = 2 * (xy - wz);
      rot[1][0] = 2 * (xy + wz);
      rot[0][2] = 2 * (xz + wy);
      rot[2][0] = 2 * (xz - wy);
      rot[1][2] = 2 * (yz - wx);
      rot[2][1] = 2 * (yz + wx);
      for (i = 0; i < 3; i++) begin
        acc = wide_t'(pose_shift[i]) <<< FRAC_Q;
        for (j = 0; j < 3; j++)
          acc = acc + wide_t'(rot[i][j]) * wide_t'(p[j]);
        acc = (acc + (wide_t'(1) <<< (FRAC_Q - 1))) >>> FRAC_Q;
        if (acc > COORD_MAX) begin
          o[i] = C_MAX;
          r.overflow = 1'b1;
        end else if (acc < COORD_MIN) begin
          o[i] = C_MIN;
          r.overflow = 1'b1;
        end else begin
          o[i] = coord_t'(acc);
        end
      end
    end
    r.out_x = o[0];
    r.out_y = o[1];
    r.out_z = o[2];
    return r;
  endfunction

  function automatic coord_t rand_coord();
    logic signed [23:0] near;
    near = 24'($urandom());
    case ($urandom_range(9))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return coord_t'(near);
      default: return coord_t'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic quat_t rand_quat(int unsigned style);
    logic signed [30:0] unit_span;
    unit_span = 31'($urandom());
    case (style)
      0: return quat_t'($urandom());
      1: return quat_t'(unit_span);
      default: begin
        case ($urandom_range(5))
          0:       return '0;
          1:       return Q_ONE;
          2:       return -Q_ONE;
          3:       return Q_HALF_SQRT2;
          4:       return -Q_HALF_SQRT2;
          default: return quat_t'(unit_span);
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [COORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      IDX_QUAT_W:  pose_quat[0] = data[QUAT_W-1:0];
      IDX_QUAT_X:  pose_quat[1] = data[QUAT_W-1:0];
      IDX_QUAT_Y:  pose_quat[2] = data[QUAT_W-1:0];
      IDX_QUAT_Z:  pose_quat[3] = data[QUAT_W-1:0];
      IDX_SHIFT_X: pose_shift[0] = data;
      IDX_SHIFT_Y: pose_shift[1] = data;
      IDX_SHIFT_Z: pose_shift[2] = data;
      IDX_POSE_EN: pose_on = data[0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_pose(quat_t w, quat_t x, quat_t y, quat_t z, coord_t sx,
                            coord_t sy, coord_t sz);
    write_reg(IDX_QUAT_W, {16'h0, w});
    write_reg(IDX_QUAT_X, {16'h0, x});
    write_reg(IDX_QUAT_Y, {16'h0, y});
    write_reg(IDX_QUAT_Z, {16'h0, z});
    write_reg(IDX_SHIFT_X, sx);
    write_reg(IDX_SHIFT_Y, sy);
    write_reg(IDX_SHIFT_Z, sz);
  endtask

  task automatic push_point(coord_t x, coord_t y, coord_t z);
    point_t pt;
    pt.x = x;
    pt.y = y;
    pt.z = z;
    point_backlog.push_back(pt);
  endtask

  // Hold until every beat is out, then let the pipeline empty.
  task automatic settle();
    do @(negedge clk_i);
    while (point_backlog.size() != 0 || point_bus.valid || transformed_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic compare_coord(string name, coord_t exp_v, coord_t act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (point_bus.valid && point_bus.ready)
        transformed_q.push_back(transform_point(
          '{point_bus.point_x, point_bus.point_y, point_bus.point_z}));
      if (!point_bus.valid || point_bus.ready) begin
        if (point_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_point = point_backlog.pop_front();
          point_bus.valid   <= 1'b1;
          point_bus.point_x <= next_point.x;
          point_bus.point_y <= next_point.y;
          point_bus.point_z <= next_point.z;
        end else begin
          point_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      hit = result_bus.valid && result_bus.ready;
      if (hit) begin
        result_cnt++;
        if (transformed_q.size() == 0) begin
          $display("%0t: unexpected beat expected none actual x=%0d y=%0d z=%0d ovf=%0b",
                   $time, result_bus.out_x, result_bus.out_y, result_bus.out_z,
                   result_bus.overflow);
          fail_cnt++;
        end else begin
          want = transformed_q.pop_front();
          compare_coord("out_x", want.out_x, result_bus.out_x);
          compare_coord("out_y", want.out_y, result_bus.out_y);
          compare_coord("out_z", want.out_z, result_bus.out_z);
          if (result_bus.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                     result_bus.overflow);
            fail_cnt++;
          end
        end
      end
      if (hit && result_cnt == HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        result_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("quaternion_pose_point_transform_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_idx_e          idx;
    logic [COORD_W-1:0] data;
    int unsigned       ph, n, style;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = IDX_QUAT_W;
    cfg_data_i = '0;
    point_bus.valid = 1'b0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    point_bus.point_z = '0;
    result_bus.ready = 1'b0;
    calm = 1'b0;
    pose_quat[0] = QUAT_W_RESET;
    pose_quat[1] = '0;
    pose_quat[2] = '0;
    pose_quat[3] = '0;
    pose_shift[0] = '0;
    pose_shift[1] = '0;
    pose_shift[2] = '0;
    pose_on = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pose absent: points pass through
    push_point(C_MAX, C_MAX, C_MAX);
    push_point(C_MIN, C_MIN, C_MIN);
    push_point('0, '1, 48'sd1);
    push_point(C_MIN, C_MAX, C_ONE);
    settle();

    // identity rotation, largest shift: saturate upwards
    write_pose(Q_ONE, '0, '0, '0, C_MAX, C_MAX, C_MAX);
    write_reg(IDX_POSE_EN, 48'h1);
    push_point(C_MAX, C_MAX, C_MAX);
    push_point(C_MIN, C_MIN, C_MIN);
    push_point('0, '0, '0);
    push_point(48'sd1, '0, '1);
    settle();

    // non-unit quaternion at its extremes, smallest shift
    write_pose(Q_MAX, Q_MIN, Q_MAX, Q_MIN, C_MIN, C_MIN, C_MIN);
    push_point(C_MAX, C_MAX, C_MAX);
    push_point(C_MIN, C_MIN, C_MIN);
    push_point(C_MAX, C_MIN, C_MAX);
    push_point(C_ONE, -C_ONE, C_ONE);
    push_point('0, '0, '0);
    settle();

    // quarter turn about z
    write_pose(Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2, '0, '0, '0);
    push_point(C_ONE, '0, '0);
    push_point('0, C_ONE, '0);
    push_point(-C_ONE, C_ONE, C_ONE);
    push_point(C_MAX, C_MIN, C_MAX);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      style = $urandom_range(2);
      idx = idx.first();
      repeat (idx.num()) begin
        if ($urandom_range(3) != 0 || ph == 0) begin
          case (idx) inside
            IDX_QUAT_W, IDX_QUAT_X, IDX_QUAT_Y, IDX_QUAT_Z:
              data = {16'($urandom()), rand_quat(style)};
            IDX_POSE_EN:
              data = {47'({$urandom(), $urandom()}), 1'($urandom_range(3) != 0)};
            default:
              data = rand_coord();
          endcase
          write_reg(idx, data);
        end
        idx = idx.next();
      end
      calm <= (ph == CALM_PHASE);
      for (n = 0; n < POINTS_PER_PHASE; n++)
        push_point(rand_coord(), rand_coord(), rand_coord());
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("quaternion_pose_point_transform_core: match");
    else
      $display("quaternion_pose_point_transform_core: mismatch");
    $finish;
  end

endmodule
